// ===== sv/pge_pkg.sv =====
`default_nettype none
package pge_pkg;

  localparam int GRID_WIDTH_DEF  = 256;
  localparam int GRID_HEIGHT_DEF = 256;

  localparam int CHAN_W    = 8;
  localparam int CELL_W    = 3 * CHAN_W;
  localparam int POS_W     = 16;
  localparam int RATE_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  localparam logic [1:0] OP_DEPOSIT = 2'd0;
  localparam logic [1:0] OP_FRAME   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  localparam logic [1:0] PHER_NONE  = 2'd0;
  localparam logic [1:0] PHER_RED   = 2'd1;
  localparam logic [1:0] PHER_GREEN = 2'd2;
  localparam logic [1:0] PHER_BLUE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PLACE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVAP_RATE  = 2'd1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_ADDR,
    ST_READ,
    ST_MODIFY,
    ST_SWEEP,
    ST_TAIL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic map;
    logic addr;
    logic mem_rd;
    logic dep_wr;
    logic sweep_step;
    logic sweep_evap;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       dep_ok;
    logic       evap_ok;
    logic       sweep_last;
    logic       out_busy;
  } sts_t;

  function automatic logic [RATE_W-1:0] advance(input logic [RATE_W-1:0] phase,
                                                input logic [RATE_W-1:0] rate);
    logic [RATE_W:0] r;
    logic [RATE_W:0] n;
    r = (rate == '0) ? (RATE_W+1)'(1) : {1'b0, rate};
    n = {1'b0, phase} + (RATE_W+1)'(1);
    return (n >= r) ? '0 : n[RATE_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/pge_ctrl.sv =====
`default_nettype none
module pge_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pge_pkg::sts_t sts,
  output pge_pkg::cmd_t      cmd
);

  pge_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pge_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      pge_pkg::ST_INIT: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = pge_pkg::ST_IDLE;
        end
      end
      pge_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = pge_pkg::ST_DECODE;
        end
      end
      pge_pkg::ST_DECODE: begin
        priority if (sts.op == pge_pkg::OP_FRAME) begin
          state_next = sts.evap_ok ? pge_pkg::ST_SWEEP : pge_pkg::ST_DONE;
        end else if (sts.op == pge_pkg::OP_CLEAR) begin
          state_next = pge_pkg::ST_SWEEP;
        end else if (sts.op == pge_pkg::OP_DEPOSIT && !sts.dep_ok) begin
          state_next = pge_pkg::ST_DONE;
        end else begin
          cmd.map    = 1'b1;
          state_next = pge_pkg::ST_ADDR;
        end
      end
      pge_pkg::ST_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = pge_pkg::ST_READ;
      end
      pge_pkg::ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = (sts.op == pge_pkg::OP_DEPOSIT) ? pge_pkg::ST_MODIFY
                                                     : pge_pkg::ST_DONE;
      end
      pge_pkg::ST_MODIFY: begin
        cmd.dep_wr = 1'b1;
        state_next = pge_pkg::ST_DONE;
      end
      pge_pkg::ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        cmd.sweep_evap = (sts.op == pge_pkg::OP_FRAME);
        if (sts.sweep_last) begin
          state_next = cmd.sweep_evap ? pge_pkg::ST_TAIL : pge_pkg::ST_DONE;
        end
      end
      pge_pkg::ST_TAIL: begin
        state_next = pge_pkg::ST_DONE;
      end
      pge_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = pge_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pge_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/pge_dp.sv =====
`default_nettype none
module pge_dp #(
  parameter int GRID_WIDTH  = pge_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = pge_pkg::GRID_HEIGHT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pge_pkg::cmd_t                 cmd,
  output pge_pkg::sts_t                      sts,
  input  wire logic [1:0]                    op,
  input  wire logic signed [pge_pkg::POS_W-1:0] pos_x,
  input  wire logic signed [pge_pkg::POS_W-1:0] pos_y,
  input  wire logic [1:0]                    pher_type,
  input  wire logic [7:0]                    intensity,
  input  wire logic [7:0]                    cell_x,
  input  wire logic [7:0]                    cell_y,
  input  wire logic                          cfg_valid,
  input  wire logic [pge_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pge_pkg::RATE_W-1:0]    cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         red,
  output logic [7:0]                         green,
  output logic [7:0]                         blue,
  output logic                               applied,
  output logic                               evaporated
);

  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = pge_pkg::CHAN_W;
  localparam int PW    = pge_pkg::POS_W;

  localparam logic [XW:0]   HALF_X = (XW+1)'(GRID_WIDTH / 2);
  localparam logic [YW:0]   HALF_Y = (YW+1)'(GRID_HEIGHT / 2);
  localparam logic [XW:0]   WID    = (XW+1)'(GRID_WIDTH);
  localparam logic [XW-1:0] X_MAX  = XW'(GRID_WIDTH - 1);
  localparam logic [YW-1:0] Y_MAX  = YW'(GRID_HEIGHT - 1);
  localparam logic [AW-1:0] A_LAST = AW'(DEPTH - 1);

  logic [pge_pkg::CELL_W-1:0] mem [DEPTH];

  logic [1:0]                    op_r;
  logic [PW-1:0]                 px_r, py_r;
  logic [1:0]                    type_r;
  logic [CW-1:0]                 inten_r;
  logic [7:0]                    cx_r, cy_r;
  logic [XW-1:0]                 x_r;
  logic [YW-1:0]                 y_r;
  logic [AW-1:0]                 addr_r;
  logic [pge_pkg::CELL_W-1:0]    rd_data;
  logic [AW-1:0]                 sweep_cnt;
  logic                          pend_valid;
  logic [AW-1:0]                 pend_addr;
  logic [pge_pkg::RATE_W-1:0]    place_rate, evap_rate;
  logic [pge_pkg::RATE_W-1:0]    place_phase, evap_phase;

  logic [XW+PW:0]                prod_x;
  logic [YW+PW:0]                prod_y;
  logic [XW+1:0]                 map_x;
  logic [YW+1:0]                 map_y;
  logic [XW-1:0]                 x_calc;
  logic [YW-1:0]                 y_calc;
  logic [AW-1:0]                 rd_addr;
  logic                          we;
  logic [AW-1:0]                 wa;
  logic [pge_pkg::CELL_W-1:0]    wd;
  logic [pge_pkg::CELL_W-1:0]    dec_data;
  logic [pge_pkg::CELL_W-1:0]    dep_data;
  logic [CW:0]                   sum;
  logic [CW-1:0]                 sat;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op;
      px_r    <= pos_x;
      py_r    <= pos_y;
      type_r  <= pher_type;
      inten_r <= intensity;
      cx_r    <= cell_x;
      cy_r    <= cell_y;
    end
  end

  // position + 1.0 in unsigned Q1.15, scaled by half the grid size
  always_comb begin
    prod_x = (XW+PW+1)'(HALF_X) * (XW+PW+1)'({~px_r[PW-1], px_r[PW-2:0]});
    prod_y = (YW+PW+1)'(HALF_Y) * (YW+PW+1)'({~py_r[PW-1], py_r[PW-2:0]});
    map_x  = prod_x[XW+PW:PW-1];
    map_y  = prod_y[YW+PW:PW-1];
    if (op_r == pge_pkg::OP_READ) begin
      x_calc = (32'(cx_r) > 32'(GRID_WIDTH - 1))  ? X_MAX : XW'(cx_r);
      y_calc = (32'(cy_r) > 32'(GRID_HEIGHT - 1)) ? Y_MAX : YW'(cy_r);
    end else begin
      x_calc = (map_x > (XW+2)'(X_MAX)) ? X_MAX : map_x[XW-1:0];
      y_calc = (map_y > (YW+2)'(Y_MAX)) ? Y_MAX : map_y[YW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map) begin
      x_r <= x_calc;
      y_r <= y_calc;
    end
    if (cmd.addr) begin
      addr_r <= AW'((YW+XW+1)'(y_r) * (YW+XW+1)'(WID) + (YW+XW+1)'(x_r));
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dec_data[c*CW +: CW] = (rd_data[c*CW +: CW] == '0) ? '0
                           : rd_data[c*CW +: CW] - CW'(1);
    end
    dep_data = rd_data;
    unique case (type_r)
      pge_pkg::PHER_RED:   sum = {1'b0, rd_data[0*CW +: CW]} + {1'b0, inten_r};
      pge_pkg::PHER_GREEN: sum = {1'b0, rd_data[1*CW +: CW]} + {1'b0, inten_r};
      default:             sum = {1'b0, rd_data[2*CW +: CW]} + {1'b0, inten_r};
    endcase
    sat = sum[CW] ? pge_pkg::CHAN_MAX : sum[CW-1:0];
    unique case (type_r)
      pge_pkg::PHER_RED:   dep_data[0*CW +: CW] = sat;
      pge_pkg::PHER_GREEN: dep_data[1*CW +: CW] = sat;
      default:             dep_data[2*CW +: CW] = sat;
    endcase
  end

  always_comb begin
    rd_addr = cmd.mem_rd ? addr_r : sweep_cnt;
    priority if (pend_valid) begin
      we = 1'b1;
      wa = pend_addr;
      wd = dec_data;
    end else if (cmd.dep_wr) begin
      we = 1'b1;
      wa = addr_r;
      wd = dep_data;
    end else if (cmd.sweep_step && !cmd.sweep_evap) begin
      we = 1'b1;
      wa = sweep_cnt;
      wd = '0;
    end else begin
      we = 1'b0;
      wa = sweep_cnt;
      wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.mem_rd || (cmd.sweep_step && cmd.sweep_evap)) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt  <= '0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= cmd.sweep_step && cmd.sweep_evap;
      if (cmd.sweep_step) begin
        sweep_cnt <= (sweep_cnt == A_LAST) ? '0 : sweep_cnt + AW'(1);
      end
    end
    pend_addr <= sweep_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      place_rate  <= pge_pkg::RATE_W'(1);
      evap_rate   <= pge_pkg::RATE_W'(1);
      place_phase <= '0;
      evap_phase  <= '0;
    end else begin
      if (cfg_valid && cfg_index == pge_pkg::CFG_PLACE_RATE) begin
        place_rate <= cfg_data;
      end
      if (cfg_valid && cfg_index == pge_pkg::CFG_EVAP_RATE) begin
        evap_rate <= cfg_data;
      end
      if (cmd.res_load && op_r == pge_pkg::OP_FRAME) begin
        place_phase <= pge_pkg::advance(place_phase, place_rate);
        evap_phase  <= pge_pkg::advance(evap_phase, evap_rate);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      red        <= (op_r == pge_pkg::OP_READ) ? rd_data[0*CW +: CW] : '0;
      green      <= (op_r == pge_pkg::OP_READ) ? rd_data[1*CW +: CW] : '0;
      blue       <= (op_r == pge_pkg::OP_READ) ? rd_data[2*CW +: CW] : '0;
      applied    <= (op_r == pge_pkg::OP_DEPOSIT) && sts.dep_ok;
      evaporated <= (op_r == pge_pkg::OP_FRAME) && sts.evap_ok;
    end
  end

  always_comb begin
    sts.op         = op_r;
    sts.dep_ok     = (place_phase == '0) && (type_r != pge_pkg::PHER_NONE);
    sts.evap_ok    = (evap_phase == '0);
    sts.sweep_last = (sweep_cnt == A_LAST);
    sts.out_busy   = out_valid && !out_ready;
  end

endmodule
`default_nettype wire

// ===== sv/pheromone_grid_engine.sv =====
// Pheromone grid: GRID_WIDTH x GRID_HEIGHT cells of three 8-bit channels in one
// single-port-write, registered-read memory. One item at a time, one result per
// item. After reset a clearing pass writes every cell with in_ready low (config
// writes still taken). Deposit and read go through map, address multiply,
// memory read and (deposit) write-back, in that order, before the result; a
// deposit that does not apply and a frame end without decay go straight to the
// result. Frame end with decay and clear walk every cell at one per cycle. The
// next input transfer is taken while a result waits in the output register.
`default_nettype none
module pheromone_grid_engine #(
  parameter int GRID_WIDTH  = pge_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = pge_pkg::GRID_HEIGHT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    op,
  input  wire logic signed [15:0]            pos_x,
  input  wire logic signed [15:0]            pos_y,
  input  wire logic [1:0]                    pher_type,
  input  wire logic [7:0]                    intensity,
  input  wire logic [7:0]                    cell_x,
  input  wire logic [7:0]                    cell_y,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         red,
  output logic [7:0]                         green,
  output logic [7:0]                         blue,
  output logic                               applied,
  output logic                               evaporated,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pge_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data
);

  pge_pkg::cmd_t cmd;
  pge_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  pge_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pge_dp #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .op         (op),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pher_type  (pher_type),
    .intensity  (intensity),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .applied    (applied),
    .evaporated (evaporated)
  );

endmodule
`default_nettype wire
